FILE: rtl/mctc_pkg.sv
// shared constants, codes and handshake structs for the mirrored correlation counter
// used by every module of the block except mctc_ram; depends on nothing
package mctc_pkg;

  localparam int MAX_IMAGE  = 64;
  localparam int MAX_FILTER = 8;

  localparam int IDX_W   = $clog2(MAX_IMAGE);
  localparam int FIDX_W  = $clog2(MAX_FILTER);
  localparam int SIZE_W  = 7;
  localparam int FSIZE_W = 4;
  localparam int VAL_W   = 16;
  localparam int THR_W   = 48;
  localparam int CNT_W   = 13;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = PROD_W + $clog2(MAX_FILTER * MAX_FILTER) + 1;

  localparam int IMG_DEPTH  = MAX_IMAGE * MAX_IMAGE;
  localparam int IMG_AW     = $clog2(IMG_DEPTH);
  localparam int COEF_DEPTH = MAX_FILTER * MAX_FILTER;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  localparam int DATA_W  = 64;
  localparam int PADDR_W = 5;
  localparam int REG_W   = 2;

  localparam logic [1:0] MODE_LOAD_IMG  = 2'd0;
  localparam logic [1:0] MODE_LOAD_COEF = 2'd1;
  localparam logic [1:0] MODE_START     = 2'd2;

  localparam logic [REG_W-1:0] REG_IMAGE_SIZE  = 2'd0;
  localparam logic [REG_W-1:0] REG_FILTER_SIZE = 2'd1;
  localparam logic [REG_W-1:0] REG_THRESHOLD   = 2'd2;

  typedef struct packed {
    logic load_img;
    logic load_coef;
    logic init;
    logic step;
    logic publish;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic too_big;
    logic last_issue;
    logic busy;
    logic out_busy;
  } stat_t;

endpackage

FILE: rtl/mctc_ram.sv
// generic single write, single read memory with registered read data
// no package dependency
module mctc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mctc_regs.sv
// configuration registers behind the apb-style port, with size clamping
// depends on mctc_pkg
module mctc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mctc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mctc_pkg::DATA_W-1:0]    pwdata,
  output logic [mctc_pkg::DATA_W-1:0]    prdata,
  output logic [mctc_pkg::SIZE_W-1:0]    n_size,
  output logic [mctc_pkg::FSIZE_W-1:0]   m_size,
  output logic signed [mctc_pkg::THR_W-1:0] thr
);
  import mctc_pkg::*;

  logic [SIZE_W-1:0]  image_size;
  logic [FSIZE_W-1:0] filter_size;
  logic [THR_W-1:0]   threshold;
  logic [REG_W-1:0]   reg_idx;
  logic               wr;

  assign reg_idx = paddr[PADDR_W-1:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= SIZE_W'(1);
      filter_size <= FSIZE_W'(1);
      threshold   <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_IMAGE_SIZE:  image_size  <= pwdata[SIZE_W-1:0];
        REG_FILTER_SIZE: filter_size <= pwdata[FSIZE_W-1:0];
        REG_THRESHOLD:   threshold   <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_SIZE:  prdata = DATA_W'(image_size);
      REG_FILTER_SIZE: prdata = DATA_W'(filter_size);
      REG_THRESHOLD:   prdata = DATA_W'(threshold);
      default:         prdata = '0;
    endcase
  end

  // zero counts as one, anything above the store side as the side
  always_comb begin
    if (image_size == '0) begin
      n_size = SIZE_W'(1);
    end else if (image_size > SIZE_W'(MAX_IMAGE)) begin
      n_size = SIZE_W'(MAX_IMAGE);
    end else begin
      n_size = image_size;
    end
    if (filter_size == '0) begin
      m_size = FSIZE_W'(1);
    end else if (filter_size > FSIZE_W'(MAX_FILTER)) begin
      m_size = FSIZE_W'(MAX_FILTER);
    end else begin
      m_size = filter_size;
    end
  end

  assign thr = $signed(threshold);

endmodule

FILE: rtl/mctc_ctrl.sv
// controller: input handshake decode and the run/drain sequence of a start
// depends on mctc_pkg
module mctc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  mctc_pkg::stat_t      stat,
  output mctc_pkg::cmd_t       cmd
);
  import mctc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state, state_next;
  logic       accept;

  // a start needs the output register free; loads go through regardless
  assign in_ready = (state == ST_IDLE) && !(stat.out_busy && mode == MODE_START);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_LOAD_IMG:  cmd.load_img  = 1'b1;
            MODE_LOAD_COEF: cmd.load_coef = 1'b1;
            MODE_START: begin
              if (stat.too_big) begin
                cmd.fail = 1'b1;
              end else begin
                cmd.init   = 1'b1;
                state_next = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/mctc_dp.sv
// datapath: image and filter stores, position counters, multiply-accumulate,
// threshold compare, count and output register; depends on mctc_pkg and mctc_ram
module mctc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mctc_pkg::cmd_t                    cmd,
  output mctc_pkg::stat_t                   stat,
  input  logic [mctc_pkg::IDX_W-1:0]        row,
  input  logic [mctc_pkg::IDX_W-1:0]        col,
  input  logic signed [mctc_pkg::VAL_W-1:0] value,
  input  logic [mctc_pkg::SIZE_W-1:0]       n_size,
  input  logic [mctc_pkg::FSIZE_W-1:0]      m_size,
  input  logic signed [mctc_pkg::THR_W-1:0] thr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mctc_pkg::CNT_W-1:0]        over_count,
  output logic                              status
);
  import mctc_pkg::*;

  logic [IDX_W-1:0]   i_cnt, j_cnt;
  logic [FIDX_W-1:0]  q_cnt, r_cnt;
  logic [SIZE_W-1:0]  last_pos;
  logic [FSIZE_W-1:0] last_tap;
  logic               i_end, j_end, q_end, r_end;

  logic [IDX_W-1:0]   img_row;
  logic [SIZE_W-1:0]  col_off, img_col;
  logic [IMG_AW-1:0]  img_waddr, img_raddr;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic               img_we, coef_we;
  logic [VAL_W-1:0]   img_rdata, coef_rdata;

  logic                     v1, f1, l1, v2, f2, l2, l3;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, prod_ext;
  logic signed [THR_W-1:0]  acc_ext;
  logic [CNT_W-1:0]         count;

  assign last_pos = n_size - SIZE_W'(m_size);
  assign last_tap = m_size - FSIZE_W'(1);
  assign r_end    = (FSIZE_W'(r_cnt) == last_tap);
  assign q_end    = (FSIZE_W'(q_cnt) == last_tap);
  assign j_end    = (SIZE_W'(j_cnt) == last_pos);
  assign i_end    = (SIZE_W'(i_cnt) == last_pos);

  assign stat.too_big    = SIZE_W'(m_size) > n_size;
  assign stat.last_issue = cmd.step && r_end && q_end && j_end && i_end;
  assign stat.busy       = v1 || v2 || l3;
  assign stat.out_busy   = out_valid;

  // mirrored column: n-1-(j+r)
  assign img_row   = i_cnt + IDX_W'(q_cnt);
  assign col_off   = SIZE_W'(j_cnt) + SIZE_W'(r_cnt);
  assign img_col   = n_size - SIZE_W'(1) - col_off;
  assign img_raddr = IMG_AW'(img_row) * IMG_AW'(MAX_IMAGE) + IMG_AW'(img_col[IDX_W-1:0]);
  assign coef_raddr = COEF_AW'(q_cnt) * COEF_AW'(MAX_FILTER) + COEF_AW'(r_cnt);

  // loads outside the store side are dropped
  assign img_we     = cmd.load_img && (row < MAX_IMAGE) && (col < MAX_IMAGE);
  assign coef_we    = cmd.load_coef && (row < MAX_FILTER) && (col < MAX_FILTER);
  assign img_waddr  = IMG_AW'(row) * IMG_AW'(MAX_IMAGE) + IMG_AW'(col);
  assign coef_waddr = COEF_AW'(row) * COEF_AW'(MAX_FILTER) + COEF_AW'(col);

  mctc_ram #(.WIDTH(VAL_W), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (value),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  mctc_ram #(.WIDTH(VAL_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // walk r, then q, then j, then i
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      i_cnt <= '0;
      j_cnt <= '0;
      q_cnt <= '0;
      r_cnt <= '0;
    end else if (cmd.step) begin
      if (r_end) begin
        r_cnt <= '0;
        if (q_end) begin
          q_cnt <= '0;
          if (j_end) begin
            j_cnt <= '0;
            i_cnt <= i_cnt + IDX_W'(1);
          end else begin
            j_cnt <= j_cnt + IDX_W'(1);
          end
        end else begin
          q_cnt <= q_cnt + FIDX_W'(1);
        end
      end else begin
        r_cnt <= r_cnt + FIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      f1 <= 1'b0;
      l1 <= 1'b0;
      v2 <= 1'b0;
      f2 <= 1'b0;
      l2 <= 1'b0;
      l3 <= 1'b0;
    end else begin
      v1 <= cmd.step;
      f1 <= cmd.step && (q_cnt == '0) && (r_cnt == '0);
      l1 <= cmd.step && q_end && r_end;
      v2 <= v1;
      f2 <= f1;
      l2 <= l1;
      l3 <= v2 && l2;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_ext  = {{(THR_W-ACC_W){acc[ACC_W-1]}}, acc};

  always_ff @(posedge clk) begin
    prod <= $signed(img_rdata) * $signed(coef_rdata);
    if (v2) begin
      acc <= f2 ? prod_ext : acc + prod_ext;
    end
  end

  // acc holds the finished sum in each cycle in which l3 is high
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      count <= '0;
    end else if (l3 && (acc_ext > thr)) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish || cmd.fail) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      over_count <= count;
      status     <= 1'b0;
    end else if (cmd.fail) begin
      over_count <= '0;
      status     <= 1'b1;
    end
  end

endmodule

FILE: rtl/mirrored_conv2d_threshold_count_core.sv
// top level of the mirrored correlation threshold counter
// depends on mctc_pkg, mctc_regs, mctc_ctrl, mctc_dp (and mctc_ram through mctc_dp)
//
// usage:
//   input channel (in_valid/in_ready) takes one transaction per item: mode 0 writes an
//   image pixel at (row, col), mode 1 a filter coefficient, mode 2 starts a count, mode 3
//   is taken and dropped. loads are taken one per cycle while the block is idle.
//   output channel (out_valid/out_ready) gives one transaction per start: over_count and
//   status. the result sits in an output register, so loads keep flowing while it waits;
//   a further start is held off until the result has been taken.
//   a start runs one multiply-accumulate per cycle through the single read port of each
//   store: (n-m+1)^2 * m^2 of them are issued, then the pipeline drains and the result is
//   published. with the filter larger than the image the result (count 0, status 1)
//   appears in the cycle after the start is taken.
//   registers sit on the apb-style port: image_size at 0x00, filter_size at 0x08,
//   threshold at 0x10; write only while idle.
//   reset (synchronous, rst high) returns the registers to 1, 1, 0 and empties the
//   output register; the stores keep their contents and must be loaded before use.
module mirrored_conv2d_threshold_count_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [mctc_pkg::IDX_W-1:0]        row,
  input  logic [mctc_pkg::IDX_W-1:0]        col,
  input  logic signed [mctc_pkg::VAL_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mctc_pkg::CNT_W-1:0]        over_count,
  output logic                              status,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mctc_pkg::PADDR_W-1:0]      paddr,
  input  logic [mctc_pkg::DATA_W-1:0]       pwdata,
  output logic [mctc_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import mctc_pkg::*;

  logic [SIZE_W-1:0]        n_size;
  logic [FSIZE_W-1:0]       m_size;
  logic signed [THR_W-1:0]  thr;
  cmd_t                     cmd;
  stat_t                    stat;

  assign pready = 1'b1;

  mctc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .n_size  (n_size),
    .m_size  (m_size),
    .thr     (thr)
  );

  mctc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  mctc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .row        (row),
    .col        (col),
    .value      (value),
    .n_size     (n_size),
    .m_size     (m_size),
    .thr        (thr),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .over_count (over_count),
    .status     (status)
  );

  // a start is never taken over a waiting result
  a_start_needs_free_output: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == MODE_START) |-> !out_valid)
    else $error("start taken while a result is waiting");

  // oversize filter answers on the next cycle with the flag set
  a_oversize_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == MODE_START && (SIZE_W'(m_size) > n_size))
    |=> (out_valid && status && over_count == '0))
    else $error("oversize filter result missing or wrong");

  // a flagged result always carries a zero count
  a_flag_zero_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (over_count == '0))
    else $error("flagged result with nonzero count");

  // no new item is taken while a count is running
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || stat.busy) |-> !in_ready)
    else $error("input ready during a running count");

endmodule
